FILE: rtl/uwcs_pkg.sv
// Shared constants, result types and helper functions of the UTF-8 column width scanner.
package uwcs_pkg;

    localparam int MAX_COLUMNS = 1024;
    localparam int WIDTH_BITS  = 14;
    localparam int COL_BITS    = $clog2(MAX_COLUMNS);
    localparam int CNT_BITS    = $clog2(MAX_COLUMNS + 1);

    localparam logic [WIDTH_BITS-1:0] WIDTH_MAX = '1;
    localparam logic [WIDTH_BITS-1:0] WIDTH_ONE = WIDTH_BITS'(1);

    localparam logic [7:0] BYTE_SPACE = 8'h20;
    localparam logic [7:0] BYTE_DASH  = 8'h2D;
    localparam logic [7:0] BYTE_CR    = 8'h0D;
    localparam logic [7:0] BYTE_LF    = 8'h0A;
    localparam logic [7:0] CONT_MASK  = 8'hC0;
    localparam logic [7:0] CONT_VALUE = 8'h80;
    localparam logic [7:0] SEP_RESET  = BYTE_SPACE;

    localparam logic REQ_BYTE = 1'b0;
    localparam logic REQ_END  = 1'b1;

    // Output queue
    localparam int FIFO_DEPTH    = 4;
    localparam int FIFO_PTR_BITS = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_BITS = $clog2(FIFO_DEPTH + 1);

    // Result beat packing
    localparam int M_FIELD_BITS = COL_BITS + 2 * WIDTH_BITS + 1 + 2 * CNT_BITS;
    localparam int M_TDATA_BITS = ((M_FIELD_BITS + 7) / 8) * 8;

    typedef enum logic [1:0] {
        KIND_FIELD = 2'd0,
        KIND_LINE  = 2'd1,
        KIND_ERROR = 2'd2
    } kind_t;

    typedef struct packed {
        kind_t                 kind;
        logic [COL_BITS-1:0]   col;
        logic [WIDTH_BITS-1:0] width;
        logic                  var_flag;
        logic [WIDTH_BITS-1:0] widest;
        logic [CNT_BITS-1:0]   fields;
        logic [CNT_BITS-1:0]   most;
        logic                  last;
    } result_t;

    // One accepted byte as it leaves the scanner; a field result always sits in first
    typedef struct packed {
        logic       valid;
        logic [1:0] count;
        logic       mem_rd;
        result_t    first;
        result_t    second;
    } scan_step_t;

    function automatic logic [WIDTH_BITS-1:0] sat_add(input logic [WIDTH_BITS-1:0] a,
                                                      input logic [WIDTH_BITS-1:0] b);
        logic [WIDTH_BITS:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[WIDTH_BITS] ? WIDTH_MAX : s[WIDTH_BITS-1:0];
    endfunction

    // {ok, continuation bytes still due}
    function automatic logic [3:0] lead_decode(input logic [7:0] b);
        logic [3:0] r;
        unique casez (b)
            8'b0???????: r = {1'b1, 3'd0};
            8'b110?????: r = {1'b1, 3'd1};
            8'b1110????: r = {1'b1, 3'd2};
            8'b11110???: r = {1'b1, 3'd3};
            8'b111110??: r = {1'b1, 3'd4};
            8'b1111110?: r = {1'b1, 3'd5};
            default:     r = {1'b0, 3'd0};
        endcase
        return r;
    endfunction

    function automatic result_t make_field(input logic [COL_BITS-1:0]   col,
                                           input logic [WIDTH_BITS-1:0] w,
                                           input logic                  dashes);
        result_t r;
        logic    v;
        r          = '0;
        v          = dashes && (w != '0);
        r.kind     = KIND_FIELD;
        r.col      = col;
        r.width    = v ? WIDTH_ONE : w;
        r.var_flag = v;
        return r;
    endfunction

    function automatic result_t make_line(input logic [CNT_BITS-1:0] fields,
                                          input logic [CNT_BITS-1:0] most);
        result_t r;
        r        = '0;
        r.kind   = KIND_LINE;
        r.fields = fields;
        r.most   = most;
        return r;
    endfunction

    function automatic result_t make_error(input logic [COL_BITS-1:0] col);
        result_t r;
        r      = '0;
        r.kind = KIND_ERROR;
        r.col  = col;
        return r;
    endfunction

endpackage

FILE: rtl/uwcs_scan.sv
// Per-byte line scanner: UTF-8 decode, field split, CR hold and line bookkeeping.
module uwcs_scan (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 accept,
    input  logic                 req_type,
    input  logic [7:0]           data_byte,
    input  logic [7:0]           sep,
    output uwcs_pkg::scan_step_t step
);

    logic                           inside_reg, inside_next;
    logic [uwcs_pkg::WIDTH_BITS-1:0] width_reg, width_next;
    logic                           dashes_reg, dashes_next;
    logic [uwcs_pkg::WIDTH_BITS-1:0] held_reg, held_next;
    logic [2:0]                     cont_reg, cont_next;
    logic [uwcs_pkg::CNT_BITS-1:0]   col_reg, col_next;
    logic                           drop_reg, drop_next;
    logic [uwcs_pkg::CNT_BITS-1:0]   largest_reg, largest_next;

    logic                           is_end;
    logic                           has_cr;
    logic [uwcs_pkg::WIDTH_BITS-1:0] width_eff;
    logic                           inside_eff;
    logic                           dashes_eff;
    logic [3:0]                     lead;
    logic [uwcs_pkg::CNT_BITS-1:0]   col_plus;
    logic [uwcs_pkg::CNT_BITS-1:0]   line_fields;
    logic [uwcs_pkg::CNT_BITS-1:0]   line_most;
    logic [uwcs_pkg::COL_BITS-1:0]   col_idx;

    assign is_end      = (req_type == uwcs_pkg::REQ_END) || (data_byte == uwcs_pkg::BYTE_LF);
    assign has_cr      = (held_reg != '0);
    assign width_eff   = has_cr ? uwcs_pkg::sat_add(width_reg, held_reg) : width_reg;
    assign inside_eff  = inside_reg || has_cr;
    assign dashes_eff  = dashes_reg && !has_cr;
    assign lead        = uwcs_pkg::lead_decode(data_byte);
    assign col_plus    = uwcs_pkg::CNT_BITS'(col_reg + 1'b1);
    assign col_idx     = col_reg[uwcs_pkg::COL_BITS-1:0];
    assign line_fields = inside_reg ? col_plus : col_reg;
    assign line_most   = (line_fields > largest_reg) ? line_fields : largest_reg;

    always_comb
    begin
        inside_next  = inside_reg;
        width_next   = width_reg;
        dashes_next  = dashes_reg;
        held_next    = held_reg;
        cont_next    = cont_reg;
        col_next     = col_reg;
        drop_next    = drop_reg;
        largest_next = largest_reg;
        step         = '0;
        step.valid   = accept;

        if (accept)
        begin
            if (is_end)
            begin
                inside_next = 1'b0;
                width_next  = '0;
                dashes_next = 1'b1;
                held_next   = '0;
                cont_next   = '0;
                col_next    = '0;
                drop_next   = 1'b0;
                if (drop_reg)
                begin
                    // only a line cut at the column limit still reports
                    if (col_reg == uwcs_pkg::CNT_BITS'(uwcs_pkg::MAX_COLUMNS))
                    begin
                        largest_next    = line_most;
                        step.count      = 2'd1;
                        step.first      = uwcs_pkg::make_line(line_fields, line_most);
                        step.first.last = 1'b1;
                    end
                end
                else if (cont_reg != '0)
                begin
                    step.count      = 2'd1;
                    step.first      = uwcs_pkg::make_error(col_idx);
                    step.first.last = 1'b1;
                end
                else
                begin
                    largest_next = line_most;
                    if (inside_reg)
                    begin
                        step.count       = 2'd2;
                        step.mem_rd      = 1'b1;
                        step.first       = uwcs_pkg::make_field(col_idx, width_reg, dashes_reg);
                        step.second      = uwcs_pkg::make_line(line_fields, line_most);
                        step.second.last = 1'b1;
                    end
                    else
                    begin
                        step.count      = 2'd1;
                        step.first      = uwcs_pkg::make_line(line_fields, line_most);
                        step.first.last = 1'b1;
                    end
                end
            end
            else if (drop_reg)
            begin
                // drop the rest of the line
            end
            else if (cont_reg != '0)
            begin
                if ((data_byte & uwcs_pkg::CONT_MASK) == uwcs_pkg::CONT_VALUE)
                begin
                    cont_next = cont_reg - 3'd1;
                end
                else
                begin
                    drop_next       = 1'b1;
                    step.count      = 2'd1;
                    step.first      = uwcs_pkg::make_error(col_idx);
                    step.first.last = 1'b1;
                end
            end
            else if (data_byte == uwcs_pkg::BYTE_CR)
            begin
                held_next = uwcs_pkg::sat_add(held_reg, uwcs_pkg::WIDTH_ONE);
            end
            else
            begin
                // held CRs become characters of the current field
                inside_next = inside_eff;
                width_next  = width_eff;
                dashes_next = dashes_eff;
                held_next   = '0;
                if (data_byte == sep)
                begin
                    if ((sep != uwcs_pkg::BYTE_SPACE) || inside_eff)
                    begin
                        step.count      = 2'd1;
                        step.mem_rd     = 1'b1;
                        step.first      = uwcs_pkg::make_field(col_idx, width_eff, dashes_eff);
                        step.first.last = 1'b1;
                        col_next        = col_plus;
                        inside_next     = 1'b0;
                        width_next      = '0;
                        dashes_next     = 1'b1;
                        if (col_plus >= uwcs_pkg::CNT_BITS'(uwcs_pkg::MAX_COLUMNS))
                        begin
                            drop_next = 1'b1;
                        end
                    end
                end
                else if (!lead[3])
                begin
                    drop_next       = 1'b1;
                    step.count      = 2'd1;
                    step.first      = uwcs_pkg::make_error(col_idx);
                    step.first.last = 1'b1;
                end
                else
                begin
                    inside_next = 1'b1;
                    width_next  = uwcs_pkg::sat_add(width_eff, uwcs_pkg::WIDTH_ONE);
                    dashes_next = dashes_eff && (data_byte == uwcs_pkg::BYTE_DASH);
                    cont_next   = lead[2:0];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inside_reg  <= 1'b0;
            width_reg   <= '0;
            dashes_reg  <= 1'b1;
            held_reg    <= '0;
            cont_reg    <= '0;
            col_reg     <= '0;
            drop_reg    <= 1'b0;
            largest_reg <= '0;
        end
        else
        begin
            inside_reg  <= inside_next;
            width_reg   <= width_next;
            dashes_reg  <= dashes_next;
            held_reg    <= held_next;
            cont_reg    <= cont_next;
            col_reg     <= col_next;
            drop_reg    <= drop_next;
            largest_reg <= largest_next;
        end
    end

    a_line_end_rewinds: assert property (@(posedge clk) disable iff (!rst_n)
        accept && is_end |=> (col_reg == '0) && !drop_reg && (cont_reg == '0))
        else $error("line end did not rewind the column");

endmodule

FILE: rtl/uwcs_col_store.sv
// Per-column widest-width memory with clearing sweep, read-modify-write and forwarding.
module uwcs_col_store (
    input  logic                 clk,
    input  logic                 rst_n,
    input  uwcs_pkg::scan_step_t step,
    output logic                 busy,
    output logic [1:0]           push_count,
    output uwcs_pkg::result_t    push0,
    output uwcs_pkg::result_t    push1
);

    typedef enum logic [1:0] {
        ST_CLEAR = 2'b01,
        ST_RUN   = 2'b10
    } store_state_t;

    store_state_t state_reg, state_next;
    logic [uwcs_pkg::COL_BITS-1:0] clr_reg, clr_next;

    logic [uwcs_pkg::WIDTH_BITS-1:0] mem [uwcs_pkg::MAX_COLUMNS];
    logic [uwcs_pkg::WIDTH_BITS-1:0] ram_q;

    uwcs_pkg::scan_step_t            s1_reg;
    logic                            fwd_hit_reg, fwd_hit_next;
    logic [uwcs_pkg::WIDTH_BITS-1:0] fwd_val_reg;

    logic                            rd_en;
    logic                            wr_en;
    logic [uwcs_pkg::COL_BITS-1:0]   wr_addr;
    logic [uwcs_pkg::WIDTH_BITS-1:0] wr_data;
    logic                            upd_en;
    logic [uwcs_pkg::WIDTH_BITS-1:0] old_widest;
    logic [uwcs_pkg::WIDTH_BITS-1:0] new_widest;

    assign busy = (state_reg == ST_CLEAR);

    always_comb
    begin
        state_next = state_reg;
        clr_next   = clr_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                clr_next = clr_reg + 1'b1;
                if (clr_reg == uwcs_pkg::COL_BITS'(uwcs_pkg::MAX_COLUMNS - 1))
                begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                clr_next = clr_reg;
            end
            default:
            begin
                state_next = ST_CLEAR;
                clr_next   = '0;
            end
        endcase
    end

    // Stage 1 merge: take the forwarded value when the previous beat wrote the same column
    assign upd_en     = s1_reg.valid && s1_reg.mem_rd;
    assign old_widest = fwd_hit_reg ? fwd_val_reg : ram_q;
    assign new_widest = (s1_reg.first.width > old_widest) ? s1_reg.first.width : old_widest;

    assign rd_en   = step.valid && step.mem_rd;
    assign wr_en   = busy || upd_en;
    assign wr_addr = busy ? clr_reg : s1_reg.first.col;
    assign wr_data = busy ? '0 : new_widest;

    assign fwd_hit_next = rd_en && upd_en && (step.first.col == s1_reg.first.col);

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            ram_q <= mem[step.first.col];
        end
    end

    always_ff @(posedge clk)
    begin
        fwd_val_reg <= new_widest;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_CLEAR;
            clr_reg     <= '0;
            s1_reg      <= '0;
            fwd_hit_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_reg     <= clr_next;
            s1_reg      <= step;
            fwd_hit_reg <= fwd_hit_next;
        end
    end

    always_comb
    begin
        push_count = s1_reg.valid ? s1_reg.count : 2'd0;
        push0      = s1_reg.first;
        push1      = s1_reg.second;
        if (upd_en)
        begin
            push0.widest = new_widest;
        end
    end

    a_no_beat_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> !step.valid)
        else $error("beat accepted during clearing sweep");

    a_widest_covers_width: assert property (@(posedge clk) disable iff (!rst_n)
        upd_en |-> (push0.widest >= push0.width))
        else $error("column maximum below field width");

endmodule

FILE: rtl/uwcs_out_fifo.sv
// Small result queue taking up to two results per cycle and sending one per beat.
module uwcs_out_fifo (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic [1:0]                          push_count,
    input  uwcs_pkg::result_t                   push0,
    input  uwcs_pkg::result_t                   push1,
    input  logic                                out_ready,
    output logic                                out_valid,
    output uwcs_pkg::result_t                   head,
    output logic [uwcs_pkg::FIFO_CNT_BITS-1:0] count
);

    uwcs_pkg::result_t entries_reg [uwcs_pkg::FIFO_DEPTH];
    logic [uwcs_pkg::FIFO_PTR_BITS-1:0] wr_ptr_reg, wr_ptr_next;
    logic [uwcs_pkg::FIFO_PTR_BITS-1:0] rd_ptr_reg, rd_ptr_next;
    logic [uwcs_pkg::FIFO_CNT_BITS-1:0] cnt_reg, cnt_next;
    logic                               pop;
    logic [uwcs_pkg::FIFO_PTR_BITS-1:0] wr_ptr_plus;

    assign out_valid   = (cnt_reg != '0);
    assign head        = entries_reg[rd_ptr_reg];
    assign count       = cnt_reg;
    assign pop         = out_valid && out_ready;
    assign wr_ptr_plus = wr_ptr_reg + 1'b1;

    assign wr_ptr_next = wr_ptr_reg + uwcs_pkg::FIFO_PTR_BITS'(push_count);
    assign rd_ptr_next = rd_ptr_reg + uwcs_pkg::FIFO_PTR_BITS'(pop);
    assign cnt_next    = cnt_reg + uwcs_pkg::FIFO_CNT_BITS'(push_count)
                                 - uwcs_pkg::FIFO_CNT_BITS'(pop);

    always_ff @(posedge clk)
    begin
        if (push_count != 2'd0)
        begin
            entries_reg[wr_ptr_reg] <= push0;
        end
        if (push_count == 2'd2)
        begin
            entries_reg[wr_ptr_plus] <= push1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        (uwcs_pkg::FIFO_CNT_BITS + 1)'(cnt_reg) + (uwcs_pkg::FIFO_CNT_BITS + 1)'(push_count)
            <= (uwcs_pkg::FIFO_CNT_BITS + 1)'(uwcs_pkg::FIFO_DEPTH)
            + (uwcs_pkg::FIFO_CNT_BITS + 1)'(pop))
        else $error("result queue overflow");

endmodule

FILE: rtl/utf8_column_width_scanner.sv
// Top level of the UTF-8 column width scanner: ports, flow control and result packing.
//
//  channel  dir  handshake          payload
//  s_*      in   s_tvalid/s_tready  s_tuser = req_type, s_tdata = data_byte
//  m_*      out  m_tvalid/m_tready  m_tuser = result_kind, m_tdata = result fields,
//                                   m_tlast = last_of_run
//  cfg_*    in   cfg_valid/cfg_ready cfg_data = field_separator
//
// One input beat per cycle while s_tready is high: the scanner, then a stage
// for the column memory read, max and write-back, then a 4-entry result queue.
// A line end closing a field yields two result beats, so the output side sets
// the rate when those are frequent.
// After reset the column memory is swept to zero with s_tready low.
// Afterwards s_tready drops only when the queue could not take two more results.
module utf8_column_width_scanner (
    input  logic                              clk,
    input  logic                              rst_n,
    // stream in
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [7:0]                        s_tdata,   // [7:0] data_byte
    input  logic                              s_tuser,   // [0] req_type
    // stream out
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [uwcs_pkg::M_TDATA_BITS-1:0] m_tdata,   // column_index, char_width,
                                                         // is_variable, column_widest,
                                                         // fields_in_line, most_fields,
                                                         // zero fill
    output logic [1:0]                        m_tuser,   // [1:0] result_kind
    output logic                              m_tlast,   // last_of_run
    // separator register
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [7:0]                        cfg_data
);

    logic [7:0]                         sep_reg;
    logic                               in_accept;
    uwcs_pkg::scan_step_t               step;
    logic                               busy;
    logic [1:0]                         push_count;
    uwcs_pkg::result_t                  push0;
    uwcs_pkg::result_t                  push1;
    uwcs_pkg::result_t                  head;
    logic [uwcs_pkg::FIFO_CNT_BITS-1:0] fifo_count;
    logic [uwcs_pkg::FIFO_CNT_BITS:0]   committed;

    // Separator register: cfg_ready stays high; a write applies from the next accepted byte
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sep_reg <= uwcs_pkg::SEP_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            sep_reg <= cfg_data;
        end
    end

    // Space reserved in the queue: what it holds plus what stage 1 pushes now.
    // Hold s_tready low unless two more results still fit.
    assign committed = (uwcs_pkg::FIFO_CNT_BITS + 1)'(fifo_count)
                     + (uwcs_pkg::FIFO_CNT_BITS + 1)'(push_count);
    assign s_tready  = !busy
                    && (committed <= (uwcs_pkg::FIFO_CNT_BITS + 1)'(uwcs_pkg::FIFO_DEPTH - 2));
    assign in_accept = s_tvalid && s_tready;

    // Stage 0: decode the byte, advance line state, issue the column read
    uwcs_scan u_scan (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (in_accept),
        .req_type  (s_tuser),
        .data_byte (s_tdata),
        .sep       (sep_reg),
        .step      (step)
    );

    // Stage 1: merge the column maximum and write it back
    uwcs_col_store u_col_store (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (step),
        .busy       (busy),
        .push_count (push_count),
        .push0      (push0),
        .push1      (push1)
    );

    // Result queue decouples stage 1 from the output stall
    uwcs_out_fifo u_out_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_count (push_count),
        .push0      (push0),
        .push1      (push1),
        .out_ready  (m_tready),
        .out_valid  (m_tvalid),
        .head       (head),
        .count      (fifo_count)
    );

    // Pack the result beat, first field in the lowest bits
    assign m_tdata = uwcs_pkg::M_TDATA_BITS'({head.most, head.fields, head.widest,
                                              head.var_flag, head.width, head.col});
    assign m_tuser = head.kind;
    assign m_tlast = head.last;

endmodule

FILE: tb/testbench.sv
// Self-checking stream testbench for the UTF-8 column width scanner.
module testbench;

    localparam int CB            = uwcs_pkg::COL_BITS;
    localparam int WB            = uwcs_pkg::WIDTH_BITS;
    localparam int NB            = uwcs_pkg::CNT_BITS;
    localparam int CAP           = (1 << WB) - 1;
    localparam int PREDICT       = -1;          // row result comes from the predictor
    localparam int SETTLE_CYCLES = 8;           // scanner, memory stage and result queue
    localparam int CYCLE_LIMIT   = 100000;
    localparam int HOLD_EVERY    = 1300;
    localparam int HOLD_CYCLES   = 150;
    localparam int LINE_ITEMS    = 85;          // random beats per separator setting
    localparam uwcs_pkg::result_t NO_RESULT = '0;

    logic                              clk       = 1'b0;
    logic                              rst_n     = 1'b0;
    logic                              s_tvalid  = 1'b0;
    logic                              s_tready;
    logic [7:0]                        s_tdata   = '0;
    logic                              s_tuser   = 1'b0;
    logic                              m_tvalid;
    logic                              m_tready  = 1'b0;
    logic [uwcs_pkg::M_TDATA_BITS-1:0] m_tdata;
    logic [1:0]                        m_tuser;
    logic                              m_tlast;
    logic                              cfg_valid = 1'b0;
    logic                              cfg_ready;
    logic [7:0]                        cfg_data  = '0;

    // Scanner state as the predictor sees it
    logic [7:0]    sep_reg;
    logic          in_field;
    logic [WB-1:0] char_count;
    logic          only_dashes;
    logic [WB-1:0] cr_pending;
    logic [2:0]    cont_due;
    logic [NB-1:0] column_now;
    logic          skip_line;
    logic [WB-1:0] column_max [uwcs_pkg::MAX_COLUMNS];
    logic [NB-1:0] most_seen;

    uwcs_pkg::result_t step_results [2];
    int                step_count;
    uwcs_pkg::result_t expected_results [$];
    int                mismatch_count = 0;
    int                cycle_count    = 0;
    int                burst_left     = 0;
    int                items_sent     = 0;
    logic [8:0]        line_beats [$];          // {req_type, data_byte} per beat

    typedef struct {
        logic              req;
        logic [7:0]        data;
        int                typed_n;
        uwcs_pkg::result_t first;
        uwcs_pkg::result_t second;
    } stim_row_t;

    stim_row_t directed_rows [$];

    utf8_column_width_scanner u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------
    function automatic logic [WB-1:0] add_capped(input logic [WB-1:0] a,
                                                 input logic [WB-1:0] b);
        int total;
        total = int'(a) + int'(b);
        return (total > CAP) ? WB'(CAP) : WB'(total);
    endfunction

    // Continuation bytes owed after a lead byte; -1 when the byte cannot start a character
    function automatic int lead_extra(input logic [7:0] b);
        int ones;
        ones = 0;
        while (ones < 8 && b[7 - ones])
            ones++;
        if (ones == 0)
            return 0;
        if (ones >= 2 && ones <= 6)
            return ones - 1;
        return -1;
    endfunction

    function automatic uwcs_pkg::result_t build_result(input uwcs_pkg::kind_t kind,
                                                       input int col, input int w,
                                                       input logic dash_only, input int widest,
                                                       input int fields, input int most);
        uwcs_pkg::result_t r;
        r          = '0;
        r.kind     = kind;
        r.col      = CB'(col);
        r.width    = WB'(w);
        r.var_flag = dash_only;
        r.widest   = WB'(widest);
        r.fields   = NB'(fields);
        r.most     = NB'(most);
        return r;
    endfunction

    function automatic void clear_field_state();
        in_field    = 1'b0;
        char_count  = '0;
        only_dashes = 1'b1;
    endfunction

    function automatic void clear_line_state();
        clear_field_state();
        cr_pending = '0;
        cont_due   = '0;
        column_now = '0;
        skip_line  = 1'b0;
    endfunction

    function automatic void reset_predictor();
        sep_reg = uwcs_pkg::SEP_RESET;
        clear_line_state();
        foreach (column_max[i])
            column_max[i] = '0;
        most_seen = '0;
    endfunction

    function automatic void close_field();
        logic [WB-1:0] w;
        logic          dash_only;
        int            col;
        col       = column_now;
        w         = char_count;
        dash_only = only_dashes && (char_count != '0);
        // a dash-only field is a variable column of width one
        if (dash_only)
            w = WB'(1);
        if (w > column_max[col])
            column_max[col] = w;
        step_results[step_count] = build_result(uwcs_pkg::KIND_FIELD, col, w, dash_only,
                                                column_max[col], 0, 0);
        step_count++;
        column_now = column_now + 1'b1;
        clear_field_state();
        if (column_now >= uwcs_pkg::MAX_COLUMNS)
            skip_line = 1'b1;
    endfunction

    function automatic void close_line();
        if (column_now > most_seen)
            most_seen = column_now;
        step_results[step_count] = build_result(uwcs_pkg::KIND_LINE, 0, 0, 1'b0, 0,
                                                column_now, most_seen);
        step_count++;
    endfunction

    function automatic void flag_error();
        step_results[step_count] = build_result(uwcs_pkg::KIND_ERROR, column_now, 0, 1'b0,
                                                0, 0, 0);
        step_count++;
    endfunction

    // Advance the predictor by one accepted beat and collect the results it causes
    function automatic void scan_item(input logic req, input logic [7:0] b);
        int extra;
        step_count = 0;
        if (req == uwcs_pkg::REQ_END || b == uwcs_pkg::BYTE_LF)
        begin
            if (skip_line)
            begin
                // a line cut off at the column limit still reports its count
                if (column_now >= uwcs_pkg::MAX_COLUMNS)
                    close_line();
            end
            else if (cont_due != '0)
                flag_error();
            else
            begin
                if (in_field)
                    close_field();
                close_line();
            end
            clear_line_state();
        end
        else if (skip_line)
        begin
        end
        else if (cont_due != '0)
        begin
            if ((b & uwcs_pkg::CONT_MASK) == uwcs_pkg::CONT_VALUE)
                cont_due = cont_due - 1'b1;
            else
            begin
                flag_error();
                skip_line = 1'b1;
            end
        end
        else if (b == uwcs_pkg::BYTE_CR)
            cr_pending = add_capped(cr_pending, WB'(1));
        else
        begin
            // held CRs turn into characters once a non line-end byte shows up
            if (cr_pending != '0)
            begin
                in_field    = 1'b1;
                char_count  = add_capped(char_count, cr_pending);
                only_dashes = 1'b0;
                cr_pending  = '0;
            end
            if (b == sep_reg)
            begin
                if (sep_reg != uwcs_pkg::BYTE_SPACE || in_field)
                    close_field();
            end
            else
            begin
                extra = lead_extra(b);
                if (extra < 0)
                begin
                    flag_error();
                    skip_line = 1'b1;
                end
                else
                begin
                    in_field   = 1'b1;
                    char_count = add_capped(char_count, WB'(1));
                    if (b != uwcs_pkg::BYTE_DASH)
                        only_dashes = 1'b0;
                    cont_due = 3'(extra);
                end
            end
        end
        if (step_count > 0)
            step_results[step_count - 1].last = 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    function automatic void add_row(input logic req, input logic [7:0] data, input int typed_n,
                                    input uwcs_pkg::result_t first,
                                    input uwcs_pkg::result_t second);
        stim_row_t row;
        row.req     = req;
        row.data    = data;
        row.typed_n = typed_n;
        row.first   = first;
        row.second  = second;
        directed_rows.push_back(row);
    endfunction

    function automatic void fill_directed_rows();
        // Skip the leading space; NUL and DEL count as plain characters.
        add_row(uwcs_pkg::REQ_BYTE, uwcs_pkg::BYTE_SPACE, 0, NO_RESULT, NO_RESULT);
        add_row(uwcs_pkg::REQ_BYTE, 8'h41, 0, NO_RESULT, NO_RESULT);
        add_row(uwcs_pkg::REQ_BYTE, 8'h00, 0, NO_RESULT, NO_RESULT);
        add_row(uwcs_pkg::REQ_BYTE, 8'h7F, 0, NO_RESULT, NO_RESULT);
        add_row(uwcs_pkg::REQ_BYTE, uwcs_pkg::BYTE_SPACE, 1,
                build_result(uwcs_pkg::KIND_FIELD, 0, 3, 1'b0, 3, 0, 0), NO_RESULT);
        // A run of spaces is one break; two dashes make a variable column.
        add_row(uwcs_pkg::REQ_BYTE, uwcs_pkg::BYTE_SPACE, 0, NO_RESULT, NO_RESULT);
        add_row(uwcs_pkg::REQ_BYTE, uwcs_pkg::BYTE_DASH, 0, NO_RESULT, NO_RESULT);
        add_row(uwcs_pkg::REQ_BYTE, uwcs_pkg::BYTE_DASH, 0, NO_RESULT, NO_RESULT);
        // Drop the held CR at the line end.
        add_row(uwcs_pkg::REQ_BYTE, uwcs_pkg::BYTE_CR, 0, NO_RESULT, NO_RESULT);
        add_row(uwcs_pkg::REQ_BYTE, uwcs_pkg::BYTE_LF, 2,
                build_result(uwcs_pkg::KIND_FIELD, 1, 1, 1'b1, 1, 0, 0),
                build_result(uwcs_pkg::KIND_LINE, 0, 0, 1'b0, 0, 2, 2));
        // Illegal lead byte; the rest of the line and its end stay silent.
        add_row(uwcs_pkg::REQ_BYTE, 8'hFF, 1,
                build_result(uwcs_pkg::KIND_ERROR, 0, 0, 1'b0, 0, 0, 0), NO_RESULT);
        add_row(uwcs_pkg::REQ_BYTE, 8'h78, 0, NO_RESULT, NO_RESULT);
        add_row(uwcs_pkg::REQ_END, 8'hFF, 0, NO_RESULT, NO_RESULT);
        // Two-byte character, then a held CR that the next byte turns into a character.
        add_row(uwcs_pkg::REQ_BYTE, 8'hC3, PREDICT, NO_RESULT, NO_RESULT);
        add_row(uwcs_pkg::REQ_BYTE, 8'hA9, PREDICT, NO_RESULT, NO_RESULT);
        add_row(uwcs_pkg::REQ_BYTE, uwcs_pkg::BYTE_CR, PREDICT, NO_RESULT, NO_RESULT);
        add_row(uwcs_pkg::REQ_BYTE, 8'h62, PREDICT, NO_RESULT, NO_RESULT);
        add_row(uwcs_pkg::REQ_BYTE, 8'hFE, 1,
                build_result(uwcs_pkg::KIND_ERROR, 0, 0, 1'b0, 0, 0, 0), NO_RESULT);
        add_row(uwcs_pkg::REQ_BYTE, uwcs_pkg::BYTE_LF, 0, NO_RESULT, NO_RESULT);
        // Line end in the middle of a five-byte sequence.
        add_row(uwcs_pkg::REQ_BYTE, 8'hF8, 0, NO_RESULT, NO_RESULT);
        add_row(uwcs_pkg::REQ_END, 8'h00, 1,
                build_result(uwcs_pkg::KIND_ERROR, 0, 0, 1'b0, 0, 0, 0), NO_RESULT);
        // Stray continuation byte where a lead is due.
        add_row(uwcs_pkg::REQ_BYTE, 8'h80, 1,
                build_result(uwcs_pkg::KIND_ERROR, 0, 0, 1'b0, 0, 0, 0), NO_RESULT);
        add_row(uwcs_pkg::REQ_BYTE, uwcs_pkg::BYTE_LF, 0, NO_RESULT, NO_RESULT);
    endfunction

    function automatic void put_byte(input logic [7:0] b);
        line_beats.push_back({uwcs_pkg::REQ_BYTE, b});
    endfunction

    function automatic logic [7:0] lead_byte(input int seq_len);
        logic [7:0] ones_mask;
        logic [7:0] payload;
        ones_mask = 8'hFF << (8 - seq_len);
        payload   = 8'($urandom) >> (seq_len + 1);
        return ones_mask | payload;
    endfunction

    // Build one line: mostly well-formed fields with random content, some noise
    function automatic void build_line();
        int fields_wanted;
        int pick;
        int seq_len;
        line_beats.delete();
        if ($urandom_range(0, 9) == 0)
        begin
            repeat ($urandom_range(1, 20))
                put_byte(8'($urandom_range(0, 255)));
            put_byte(uwcs_pkg::BYTE_LF);
            return;
        end
        if ($urandom_range(0, 7) == 0)
            repeat ($urandom_range(1, 3))
                put_byte(sep_reg);
        fields_wanted = $urandom_range(0, 6);
        for (int f = 0; f < fields_wanted; f++)
        begin
            if ($urandom_range(0, 7) == 0)
                repeat ($urandom_range(1, 3))
                    put_byte(uwcs_pkg::BYTE_DASH);
            else
            begin
                repeat ($urandom_range(0, 6))
                begin
                    pick = $urandom_range(0, 99);
                    if (pick < 50)
                        put_byte(8'($urandom_range(8'h21, 8'h7E)));
                    else if (pick < 58)
                        put_byte(uwcs_pkg::BYTE_DASH);
                    else if (pick < 80)
                    begin
                        seq_len = $urandom_range(2, 6);
                        put_byte(lead_byte(seq_len));
                        for (int c = 1; c < seq_len; c++)
                        begin
                            // now and then break the sequence with a plain byte
                            if ($urandom_range(0, 29) == 0)
                                put_byte(8'($urandom_range(0, 127)));
                            else
                                put_byte({2'b10, 6'($urandom)});
                        end
                    end
                    else if (pick < 87)
                        repeat ($urandom_range(1, 2))
                            put_byte(uwcs_pkg::BYTE_CR);
                    else if (pick < 94)
                        put_byte(8'($urandom_range(0, 255)));
                    else
                        put_byte($urandom_range(0, 1) ? 8'h00 : 8'h7F);
                end
            end
            if (f < fields_wanted - 1 || $urandom_range(0, 3) == 0)
                repeat ($urandom_range(1, 2))
                    put_byte(sep_reg);
        end
        pick = $urandom_range(0, 9);
        if (pick < 6)
            put_byte(uwcs_pkg::BYTE_LF);
        else if (pick < 8)
            line_beats.push_back({uwcs_pkg::REQ_END, 8'($urandom)});
        else
        begin
            put_byte(uwcs_pkg::BYTE_CR);
            put_byte(uwcs_pkg::BYTE_LF);
        end
    endfunction

    // Offer one beat, wait for the handshake, then log what it should produce
    task automatic send_beat(input logic req, input logic [7:0] b, input int typed_n,
                             input uwcs_pkg::result_t first, input uwcs_pkg::result_t second);
        int gap;
        s_tvalid <= 1'b1;
        s_tuser  <= req;
        s_tdata  <= b;
        do
            @(posedge clk);
        while (!s_tready);
        scan_item(req, b);
        if (typed_n == PREDICT)
        begin
            for (int i = 0; i < step_count; i++)
                expected_results.push_back(step_results[i]);
        end
        else
        begin
            first.last  = (typed_n == 1);
            second.last = 1'b1;
            if (typed_n > 0)
                expected_results.push_back(first);
            if (typed_n > 1)
                expected_results.push_back(second);
        end
        items_sent++;
        burst_left--;
        // end of a burst: pick the next burst length and maybe idle for a while
        if (burst_left <= 0)
        begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 8) : $urandom_range(0, 2);
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    task automatic send_line();
        foreach (line_beats[i])
            send_beat(line_beats[i][8], line_beats[i][7:0], PREDICT, NO_RESULT, NO_RESULT);
    endtask

    // Drop valid, let every expected beat arrive, then cover beats still in flight
    task automatic wait_for_idle();
        s_tvalid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_separator(input logic [7:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        sep_reg = value;
    endtask

    initial
    begin : main_flow
        logic [7:0] sep_plan [9];
        sep_plan = '{8'h2C, 8'h00, 8'hFF, uwcs_pkg::BYTE_CR, uwcs_pkg::BYTE_LF,
                     uwcs_pkg::BYTE_DASH, 8'h85, 8'h09, uwcs_pkg::BYTE_SPACE};
        reset_predictor();
        fill_directed_rows();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // The column memory sweep after reset simply shows up as s_tready low.
        foreach (directed_rows[i])
            send_beat(directed_rows[i].req, directed_rows[i].data, directed_rows[i].typed_n,
                      directed_rows[i].first, directed_rows[i].second);

        foreach (sep_plan[p])
        begin
            wait_for_idle();
            write_separator(sep_plan[p]);
            items_sent = 0;
            while (items_sent < LINE_ITEMS)
            begin
                build_line();
                send_line();
            end
            // Leave a line open now and then so the next separator lands mid-line.
            if ($urandom_range(0, 1))
            begin
                line_beats.delete();
                repeat ($urandom_range(1, 3))
                    put_byte(8'($urandom_range(8'h21, 8'h7E)));
                send_line();
            end
        end

        wait_for_idle();
        if (mismatch_count == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    // ------------------------------------------------------------------
    // Receiver pacing: random stall segments plus a periodic long hold-off
    // that lets the result queue fill and back-pressure the input.
    // ------------------------------------------------------------------
    initial
    begin : rx_pacing
        int seg_left;
        int stall_pct;
        int since_hold;
        seg_left   = 0;
        stall_pct  = 0;
        since_hold = 0;
        forever
        begin
            @(posedge clk);
            since_hold++;
            if (since_hold >= HOLD_EVERY)
            begin
                since_hold = 0;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            if (seg_left == 0)
            begin
                seg_left = $urandom_range(16, 160);
                case ($urandom_range(0, 3))
                    0:       stall_pct = 0;
                    1:       stall_pct = 20;
                    2:       stall_pct = 50;
                    default: stall_pct = 85;
                endcase
            end
            seg_left--;
            m_tready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    // ------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------
    function automatic void check_field(input string name, input int want, input int seen);
        if (want != seen)
        begin
            mismatch_count++;
            $display("%0t: %s expected %0d actual %0d", $time, name, want, seen);
        end
    endfunction

    always @(posedge clk)
    begin : result_check
        uwcs_pkg::result_t seen;
        uwcs_pkg::result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            seen          = '0;
            seen.kind     = uwcs_pkg::kind_t'(m_tuser);
            seen.col      = m_tdata[CB-1:0];
            seen.width    = m_tdata[CB +: WB];
            seen.var_flag = m_tdata[CB + WB];
            seen.widest   = m_tdata[CB + WB + 1 +: WB];
            seen.fields   = m_tdata[CB + 2 * WB + 1 +: NB];
            seen.most     = m_tdata[CB + 2 * WB + 1 + NB +: NB];
            seen.last     = m_tlast;
            if (expected_results.size() == 0)
            begin
                mismatch_count++;
                $display("%0t: result beat with none expected: expected none actual kind %0d",
                         $time, m_tuser);
            end
            else
            begin
                want = expected_results.pop_front();
                check_field("result_kind", want.kind, seen.kind);
                check_field("column_index", want.col, seen.col);
                check_field("char_width", want.width, seen.width);
                check_field("is_variable", want.var_flag, seen.var_flag);
                check_field("column_widest", want.widest, seen.widest);
                check_field("fields_in_line", want.fields, seen.fields);
                check_field("most_fields", want.most, seen.most);
                check_field("last_of_run", want.last, seen.last);
            end
        end
    end

    always @(posedge clk)
    begin : watchdog
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("FAILED: results differ");
            $finish;
        end
    end

endmodule

FILE: files.f
rtl/uwcs_pkg.sv
rtl/uwcs_scan.sv
rtl/uwcs_col_store.sv
rtl/uwcs_out_fifo.sv
rtl/utf8_column_width_scanner.sv
tb/testbench.sv
